// ----- hdl/bgu_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgu_pkg : shared types and constants for the bilinear grid upscaler
// Field widths, parameter defaults, controller state and the command and
// status words between controller and datapath.
// -----------------------------------------------------------------------------
package bgu_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COORD_W  = 7;
   localparam int VALUE_W  = 24;
   localparam int FRAC_W   = 8;

   localparam int GRID_ROWS_DEF  = 20;
   localparam int GRID_COLS_DEF  = 20;
   localparam int SCALE_ROWS_DEF = 4;
   localparam int SCALE_COLS_DEF = 4;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_PREP,
      CTL_ISSUE
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic prep;     // load cell coefficients, tail write of the row store
      logic issue;    // push one (m,n) point into the pipeline
      logic row_end;  // current point is the last of its m row
      logic last;     // current point is the last of the cell
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cell_done; // last accepted word completes a cell
      logic adv;       // pipeline may advance this cycle
   } status_type;

endpackage

// ----- hdl/bilinear_grid_upscaler_core.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bilinear_grid_upscaler_core : bilinear upscaler for a streamed sample grid
// Samples arrive row-major on req_*; each sample that closes a grid cell
// yields SCALE_ROWS*SCALE_COLS interpolated Q.8 words on rsp_*.
// -----------------------------------------------------------------------------
// Usage
//  - req_valid/req_sample carry one grid sample per word; req_stall high
//    means the word is held. rsp_* carries one interpolated point per word,
//    m-major then n, with last_of_run on the final point of a cell.
//  - A sample in the first row or first column only fills the row store.
//    A sample that closes cell (i,j) is first accepted, then the cell
//    coefficients are loaded, then one point per cycle, unless rsp_stall
//    holds the pipeline, is issued into a three stage pipeline
//    (numerator, reciprocal multiply, result register).
//  - The first point shows on rsp_valid once it has passed the pipeline
//    stages; the next sample may be accepted while the tail drains.
//  - rsp_stall with rsp_valid high freezes the whole pipeline and holds the
//    output word; issue pauses with it, so nothing is lost.
//  - Reset returns the position to (0,0) and empties the pipeline. The row
//    store is not cleared; it is always written before it is read.
//  - The position wraps to (0,0) after the last sample of the grid.
// -----------------------------------------------------------------------------
module bilinear_grid_upscaler_core #(
   parameter int GRID_ROWS  = bgu_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS  = bgu_pkg::GRID_COLS_DEF,
   parameter int SCALE_ROWS = bgu_pkg::SCALE_ROWS_DEF,
   parameter int SCALE_COLS = bgu_pkg::SCALE_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bgu_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bgu_pkg::COORD_W-1:0]         rsp_out_row,
   output logic [bgu_pkg::COORD_W-1:0]         rsp_out_col,
   output logic signed [bgu_pkg::VALUE_W-1:0]  rsp_value_q8,
   output logic                                rsp_last_of_run
);
   import bgu_pkg::*;

   // point counter widths; a scale of one still keeps a one bit counter
   localparam int MW = (SCALE_ROWS > 1) ? $clog2(SCALE_ROWS) : 1;
   localparam int NW = (SCALE_COLS > 1) ? $clog2(SCALE_COLS) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [MW-1:0] m_idx;
   logic [NW-1:0] n_idx;

   // sequencing: accept, coefficient load, point issue
   bgu_ctrl #(
      .SCALE_ROWS (SCALE_ROWS),
      .SCALE_COLS (SCALE_COLS),
      .MW         (MW),
      .NW         (NW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .m_idx     (m_idx),
      .n_idx     (n_idx)
   );

   // row store, corners and the interpolation pipeline
   bgu_datapath #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .SCALE_ROWS (SCALE_ROWS),
      .SCALE_COLS (SCALE_COLS),
      .MW         (MW),
      .NW         (NW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .m_idx           (m_idx),
      .n_idx           (n_idx),
      .status          (status),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_value_q8    (rsp_value_q8),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- hdl/bgu_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgu_ctrl : sequencing controller
// Takes input words, steps through the m/n points of a completed cell and
// paces issue against the datapath pipeline.
// -----------------------------------------------------------------------------
module bgu_ctrl #(
   parameter int SCALE_ROWS = bgu_pkg::SCALE_ROWS_DEF,
   parameter int SCALE_COLS = bgu_pkg::SCALE_COLS_DEF,
   parameter int MW         = 2,
   parameter int NW         = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bgu_pkg::status_type status,
   output bgu_pkg::cmd_type    cmd,
   output logic [MW-1:0]       m_idx,
   output logic [NW-1:0]       n_idx
);
   import bgu_pkg::*;

   localparam logic [MW-1:0] M_LAST = MW'(SCALE_ROWS - 1);
   localparam logic [NW-1:0] N_LAST = NW'(SCALE_COLS - 1);

   ctl_state_type state_ff, state_in;
   logic [MW-1:0] m_ff, m_in;
   logic [NW-1:0] n_ff, n_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         m_ff     <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         m_ff     <= m_in;
         n_ff     <= n_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      cmd.accept  = 1'b0;
      cmd.prep    = 1'b0;
      cmd.issue   = 1'b0;
      cmd.row_end = (n_ff == N_LAST);
      cmd.last    = (n_ff == N_LAST) && (m_ff == M_LAST);
      req_stall   = (state_ff != CTL_IDLE);
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = CTL_PREP;
            end
         end
         CTL_PREP: begin
            cmd.prep = 1'b1;
            m_in     = '0;
            n_in     = '0;
            state_in = status.cell_done ? CTL_ISSUE : CTL_IDLE;
         end
         CTL_ISSUE: begin
            if (status.adv) begin
               cmd.issue = 1'b1;
               if (cmd.row_end) begin
                  n_in = '0;
                  m_in = m_ff + 1'b1;
               end else begin
                  n_in = n_ff + 1'b1;
               end
               if (cmd.last) begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign m_idx = m_ff;
   assign n_idx = n_ff;

endmodule

// ----- hdl/bgu_datapath.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgu_datapath : row store, corner registers and interpolation pipeline
// Incremental numerator, floored division by the cell area through a
// reciprocal multiply, and the output register.
// -----------------------------------------------------------------------------
module bgu_datapath #(
   parameter int GRID_ROWS  = bgu_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS  = bgu_pkg::GRID_COLS_DEF,
   parameter int SCALE_ROWS = bgu_pkg::SCALE_ROWS_DEF,
   parameter int SCALE_COLS = bgu_pkg::SCALE_COLS_DEF,
   parameter int MW         = 2,
   parameter int NW         = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bgu_pkg::cmd_type                     cmd,
   input  logic [MW-1:0]                        m_idx,
   input  logic [NW-1:0]                        n_idx,
   output bgu_pkg::status_type                  status,
   input  logic signed [bgu_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bgu_pkg::COORD_W-1:0]          rsp_out_row,
   output logic [bgu_pkg::COORD_W-1:0]          rsp_out_col,
   output logic signed [bgu_pkg::VALUE_W-1:0]   rsp_value_q8,
   output logic                                 rsp_last_of_run
);
   import bgu_pkg::*;

   localparam int AREA  = SCALE_ROWS * SCALE_COLS;
   localparam int LOG_A = $clog2(AREA);
   localparam int NUM_W = SAMPLE_W + 2 + LOG_A;
   localparam int TQ_W  = NUM_W + FRAC_W;
   localparam int DIV_W = NUM_W + 7;
   localparam int PRD_W = 2 * DIV_W + 1;
   localparam int QW    = PRD_W - DIV_W - LOG_A;
   localparam int CW    = $clog2(GRID_COLS);
   localparam int RW    = $clog2(GRID_ROWS);

   localparam longint unsigned RECIP =
      ((64'd1 << (DIV_W + LOG_A)) + 64'(AREA) - 64'd1) / 64'(AREA);
   localparam logic [DIV_W:0]          RECIP_C = RECIP[DIV_W:0];
   localparam logic signed [NUM_W-1:0] SX      = NUM_W'(SCALE_ROWS);
   localparam logic signed [NUM_W-1:0] SY      = NUM_W'(SCALE_COLS);
   localparam logic [CW-1:0]           COL_END = CW'(GRID_COLS - 1);
   localparam logic [RW-1:0]           ROW_END = RW'(GRID_ROWS - 1);

   // row store and sample history
   logic signed [SAMPLE_W-1:0] row_mem [GRID_COLS];
   logic signed [SAMPLE_W-1:0] top_ff, top_prev_ff, v2_ff, v3_ff;
   logic [CW-1:0]              col_pos_ff, col_pos_in;
   logic [RW-1:0]              row_pos_ff, row_pos_in;
   logic [CW-1:0]              wr_addr;
   logic                       cell_ff, tail_ff;
   logic [COORD_W-1:0]         cell_row_ff, cell_col_ff;

   // cell coefficients and numerator walk
   logic signed [NUM_W-1:0] d_ff, yb_ff, step_ff, base_ff, acc_ff;
   logic signed [NUM_W-1:0] d_in, a_ext, b_ext;

   // pipeline
   logic                       adv;
   logic                       vld1_ff, vld2_ff, out_vld_ff;
   logic [DIV_W-1:0]           x1_ff;
   logic                       neg1_ff, neg2_ff;
   logic [COORD_W-1:0]         row1_ff, col1_ff, row2_ff, col2_ff;
   logic                       last1_ff, last2_ff;
   logic signed [SAMPLE_W-1:0] v1_1_ff, v1_2_ff;
   logic [PRD_W-1:0]           prod2_ff;
   logic signed [TQ_W-1:0]     t_s;
   logic [TQ_W-1:0]            mag;
   logic [QW-1:0]              quo;
   logic signed [TQ_W-1:0]     val;
   logic [COORD_W-1:0]         out_row_ff, out_col_ff;
   logic signed [VALUE_W-1:0]  out_val_ff;
   logic                       out_last_ff;

   assign wr_addr = col_pos_ff - 1'b1;

   always_comb begin
      col_pos_in = col_pos_ff + 1'b1;
      row_pos_in = row_pos_ff;
      if (col_pos_ff == COL_END) begin
         col_pos_in = '0;
         row_pos_in = (row_pos_ff == ROW_END) ? '0 : row_pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         cell_ff    <= 1'b0;
         tail_ff    <= 1'b0;
      end else if (cmd.accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         cell_ff    <= (row_pos_ff != '0) && (col_pos_ff != '0);
         tail_ff    <= (col_pos_ff == COL_END);
      end
   end

   // row store: read the entry above at accept, write back one column late
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         top_ff <= row_mem[col_pos_ff];
         if (col_pos_ff != '0) begin
            row_mem[wr_addr] <= v3_ff;
         end
      end else if (cmd.prep && tail_ff) begin
         row_mem[COL_END] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         top_prev_ff <= top_ff;
         v2_ff       <= v3_ff;
         v3_ff       <= req_sample;
         cell_row_ff <= COORD_W'((int'(row_pos_ff) - 1) * SCALE_ROWS);
         cell_col_ff <= COORD_W'((int'(col_pos_ff) - 1) * SCALE_COLS);
      end
   end

   // V1 = top_prev, V2 = v2, V3 = v3, V4 = top
   always_comb begin
      d_in  = NUM_W'(v3_ff) - NUM_W'(top_ff) - NUM_W'(v2_ff) + NUM_W'(top_prev_ff);
      a_ext = NUM_W'(top_ff) - NUM_W'(top_prev_ff);
      b_ext = NUM_W'(v2_ff) - NUM_W'(top_prev_ff);
   end

   // numerator steps by m*D + X*A along n, rows start at m*Y*B
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         d_ff    <= d_in;
         yb_ff   <= b_ext * SY;
         step_ff <= a_ext * SX;
         base_ff <= '0;
         acc_ff  <= '0;
      end else if (cmd.issue) begin
         if (cmd.row_end) begin
            acc_ff  <= base_ff + yb_ff;
            base_ff <= base_ff + yb_ff;
            step_ff <= step_ff + d_ff;
         end else begin
            acc_ff  <= acc_ff + step_ff;
         end
      end
   end

   assign adv = !out_vld_ff || !rsp_stall;

   // stage 1: scale by 256, magnitude with floor bias for negatives
   always_comb begin
      t_s = TQ_W'(acc_ff) <<< FRAC_W;
      if (acc_ff[NUM_W-1]) begin
         mag = (TQ_W'(0) - t_s) + TQ_W'(AREA - 1);
      end else begin
         mag = t_s;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         x1_ff    <= mag[DIV_W-1:0];
         neg1_ff  <= acc_ff[NUM_W-1];
         row1_ff  <= cell_row_ff + COORD_W'(m_idx);
         col1_ff  <= cell_col_ff + COORD_W'(n_idx);
         last1_ff <= cmd.last;
         v1_1_ff  <= top_prev_ff;
      end
   end

   // stage 2: reciprocal multiply
   always_ff @(posedge clock) begin
      if (adv && vld1_ff) begin
         prod2_ff <= x1_ff * RECIP_C;
         neg2_ff  <= neg1_ff;
         row2_ff  <= row1_ff;
         col2_ff  <= col1_ff;
         last2_ff <= last1_ff;
         v1_2_ff  <= v1_1_ff;
      end
   end

   // stage 3: quotient, sign, add the V1 corner
   always_comb begin
      quo = prod2_ff[PRD_W-1:DIV_W+LOG_A];
      val = (TQ_W'(v1_2_ff) <<< FRAC_W)
          + (neg2_ff ? (TQ_W'(0) - TQ_W'(quo)) : TQ_W'(quo));
   end

   always_ff @(posedge clock) begin
      if (adv && vld2_ff) begin
         out_row_ff  <= row2_ff;
         out_col_ff  <= col2_ff;
         out_val_ff  <= val[VALUE_W-1:0];
         out_last_ff <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff    <= cmd.issue;
         vld2_ff    <= vld1_ff;
         out_vld_ff <= vld2_ff;
      end
   end

   assign status.cell_done = cell_ff;
   assign status.adv       = adv;
   assign rsp_valid        = out_vld_ff;
   assign rsp_out_row      = out_row_ff;
   assign rsp_out_col      = out_col_ff;
   assign rsp_value_q8     = out_val_ff;
   assign rsp_last_of_run  = out_last_ff;

endmodule
